>>> src/bfgl_pkg.sv
// shared types, constants and register codes of the glyph layout block
`default_nettype none

package bfgl_pkg;

    // field widths
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned GLYPH_W    = 7;
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned CELL_W     = 8;
    localparam int unsigned ATLAS_W    = 11;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned M_DATA_W   = 72;

    // default depth of the queue between front and back end
    localparam int unsigned QUEUE_DEPTH = 2;

    // number of glyph cells in the font order
    localparam logic [GLYPH_W-1:0] GLYPH_COUNT = 7'd96;
    localparam logic [GLYPH_W-1:0] SPACE_POS   = 7'd95;

    // character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] FIRST_CODE   = 8'h21;
    localparam logic [CHAR_W-1:0] BRACE_CODE   = 8'h7B;
    localparam logic [CHAR_W-1:0] BAR_CODE     = 8'h7C;
    localparam logic [CHAR_W-1:0] TILDE_CODE   = 8'h7E;
    // offset for codes after the unreachable duplicate backslash cell
    localparam logic [CHAR_W-1:0] BAR_OFFSET   = 8'h20;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_GLYPH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_PADDING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd5;

    // register reset values
    localparam logic [CELL_W-1:0]  CELL_WIDTH_RST    = 8'd8;
    localparam logic [CELL_W-1:0]  CELL_HEIGHT_RST   = 8'd8;
    localparam logic [CELL_W-1:0]  GLYPH_PADDING_RST = 8'd0;
    localparam logic [ATLAS_W-1:0] ATLAS_WIDTH_RST   = 11'd128;
    localparam logic [CELL_W-1:0]  ORIGIN_X_RST      = 8'd0;
    localparam logic [CELL_W-1:0]  ORIGIN_Y_RST      = 8'd0;

    // configuration register file
    typedef struct packed {
        logic [CELL_W-1:0]  cell_width;
        logic [CELL_W-1:0]  cell_height;
        logic [CELL_W-1:0]  glyph_padding;
        logic [ATLAS_W-1:0] atlas_width;
        logic [CELL_W-1:0]  origin_x;
        logic [CELL_W-1:0]  origin_y;
    } cfg_t;

    // classified request handed from front to back end
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [GLYPH_W-1:0] glyph_index;
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
    } entry_t;

endpackage

`default_nettype wire

>>> src/bfgl_front.sv
// front end: accepts characters, classifies them and keeps the pen position
`default_nettype none

module bfgl_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire bfgl_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [bfgl_pkg::CHAR_W-1:0] char_code,
    input  wire logic            first_of_message,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output bfgl_pkg::entry_t     push_entry
);

    logic [bfgl_pkg::COORD_W-1:0] pen_x_reg, pen_x_next;
    logic [bfgl_pkg::COORD_W-1:0] pen_y_reg, pen_y_next;
    logic [bfgl_pkg::COORD_W-1:0] base_x, base_y;
    logic [bfgl_pkg::COORD_W-1:0] cw_ext, ch_ext, pad_ext;
    logic [bfgl_pkg::CHAR_W-1:0]  diff_low, diff_high;
    logic                         is_low, is_high, is_space;
    logic                         accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid & push_ready;

    assign cw_ext  = {8'd0, cfg.cell_width};
    assign ch_ext  = {8'd0, cfg.cell_height};
    assign pad_ext = {8'd0, cfg.glyph_padding};

    // first of message starts from a cleared pen
    assign base_x = first_of_message ? '0 : pen_x_reg;
    assign base_y = first_of_message ? '0 : pen_y_reg;

    // font order lookup
    assign is_low    = (char_code >= bfgl_pkg::FIRST_CODE) && (char_code <= bfgl_pkg::BRACE_CODE);
    assign is_high   = (char_code >= bfgl_pkg::BAR_CODE) && (char_code <= bfgl_pkg::TILDE_CODE);
    assign is_space  = (char_code == bfgl_pkg::SPACE_CODE);
    assign diff_low  = char_code - bfgl_pkg::FIRST_CODE;
    assign diff_high = char_code - bfgl_pkg::BAR_OFFSET;

    // classify and compute screen position and next pen
    always_comb begin
        push_entry = '0;
        pen_x_next = base_x;
        pen_y_next = base_y;
        if (char_code == bfgl_pkg::NEWLINE_CODE) begin
            push_entry.kind = bfgl_pkg::KIND_NEWLINE;
            pen_x_next      = '0;
            pen_y_next      = base_y + ch_ext + pad_ext;
        end else if (is_low || is_high || is_space) begin
            push_entry.kind     = bfgl_pkg::KIND_GLYPH;
            push_entry.screen_x = {8'd0, cfg.origin_x} + base_x;
            push_entry.screen_y = {8'd0, cfg.origin_y} + base_y;
            pen_x_next          = base_x + cw_ext + pad_ext;
            if (is_low) begin
                push_entry.glyph_index = diff_low[bfgl_pkg::GLYPH_W-1:0];
            end else if (is_high) begin
                push_entry.glyph_index = diff_high[bfgl_pkg::GLYPH_W-1:0];
            end else begin
                push_entry.glyph_index = bfgl_pkg::SPACE_POS;
            end
        end else begin
            push_entry.kind = bfgl_pkg::KIND_UNKNOWN;
        end
    end

    // pen registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end else if (accept) begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

endmodule

`default_nettype wire

>>> src/bfgl_queue.sv
// short fifo of classified requests between front and back end
`default_nettype none

module bfgl_queue #(
    parameter int unsigned DEPTH = bfgl_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire bfgl_pkg::entry_t  push_entry,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output bfgl_pkg::entry_t       pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bfgl_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push_fire, pop_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid & push_ready;
    assign pop_fire   = pop_valid & pop_ready;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> src/bfgl_back.sv
// back end: steps the atlas cell position and holds the result register
`default_nettype none

module bfgl_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bfgl_pkg::cfg_t    cfg,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire bfgl_pkg::entry_t  pop_entry,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [bfgl_pkg::KIND_W-1:0]  out_kind,
    output logic [bfgl_pkg::GLYPH_W-1:0] out_glyph_index,
    output logic [bfgl_pkg::COORD_W-1:0] out_screen_x,
    output logic [bfgl_pkg::COORD_W-1:0] out_screen_y,
    output logic [bfgl_pkg::COORD_W-1:0] out_atlas_u,
    output logic [bfgl_pkg::COORD_W-1:0] out_atlas_v
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    bfgl_pkg::entry_t               entry_reg, entry_next;
    logic [bfgl_pkg::GLYPH_W-1:0]   count_reg, count_next;
    logic [bfgl_pkg::ATLAS_W-1:0]   u_reg, u_next;
    logic [bfgl_pkg::COORD_W-1:0]   v_reg, v_next;
    logic [bfgl_pkg::ATLAS_W:0]     u_sum;
    logic                           load;
    logic                           out_valid_reg, out_valid_next;
    logic [bfgl_pkg::KIND_W-1:0]    out_kind_reg;
    logic [bfgl_pkg::GLYPH_W-1:0]   out_glyph_reg;
    logic [bfgl_pkg::COORD_W-1:0]   out_sx_reg, out_sy_reg, out_u_reg, out_v_reg;

    assign pop_ready = (state_reg == ST_IDLE);
    // u stays below atlas width, so one extra bit holds the sum
    assign u_sum = {1'b0, u_reg} + {4'd0, cfg.cell_width};

    // stepping sequencer
    always_comb begin
        state_next = state_reg;
        entry_next = entry_reg;
        count_next = count_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    entry_next = pop_entry;
                    count_next = pop_entry.glyph_index;
                    u_next     = '0;
                    v_next     = '0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (count_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    count_next = count_reg - 1'b1;
                    if (u_sum >= {1'b0, cfg.atlas_width}) begin
                        u_next = '0;
                        v_next = v_reg + {8'd0, cfg.cell_height};
                    end else begin
                        u_next = u_sum[bfgl_pkg::ATLAS_W-1:0];
                    end
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        count_reg <= count_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        if (load) begin
            out_kind_reg  <= entry_reg.kind;
            out_glyph_reg <= entry_reg.glyph_index;
            out_sx_reg    <= entry_reg.screen_x;
            out_sy_reg    <= entry_reg.screen_y;
            out_u_reg     <= {5'd0, u_reg};
            out_v_reg     <= v_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_glyph_index = out_glyph_reg;
    assign out_screen_x    = out_sx_reg;
    assign out_screen_y    = out_sy_reg;
    assign out_atlas_u     = out_u_reg;
    assign out_atlas_v     = out_v_reg;

endmodule

`default_nettype wire

>>> src/bitmap_font_glyph_layout.sv
// top level of the bitmap font glyph layout block
// A request passes the combinational front end, the queue, the back end atlas stepper
// (which advances over the p cells before font position p) and the result register.
// The back end takes a new request only once the last one's result is loaded, stepping one
// cell a cycle; the front end keeps taking requests into the queue while it has room.
// Reset (aresetn low, synchronous): pen cleared, registers to defaults, queue and result empty.
`default_nettype none

module bitmap_font_glyph_layout #(
    parameter int unsigned QUEUE_DEPTH = bfgl_pkg::QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // input requests
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bfgl_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] char_code
    input  wire logic                           s_tuser,   // [0] first_of_message
    // results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bfgl_pkg::M_DATA_W-1:0]       m_tdata,   // [6:0] glyph_index, [22:7] screen_x,
                                                           // [38:23] screen_y, [54:39] atlas_u,
                                                           // [70:55] atlas_v, [71] zero
    output logic [bfgl_pkg::KIND_W-1:0]         m_tuser,   // [1:0] kind
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bfgl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bfgl_pkg::CFG_DATA_W-1:0] cfg_data
);

    bfgl_pkg::cfg_t   cfg_reg, cfg_next;
    bfgl_pkg::entry_t push_entry, pop_entry;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    logic [bfgl_pkg::KIND_W-1:0]  out_kind;
    logic [bfgl_pkg::GLYPH_W-1:0] out_glyph_index;
    logic [bfgl_pkg::COORD_W-1:0] out_screen_x, out_screen_y, out_atlas_u, out_atlas_v;

    assign cfg_ready = 1'b1;

    // configuration register file
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                bfgl_pkg::REG_CELL_WIDTH:    cfg_next.cell_width    = cfg_data[7:0];
                bfgl_pkg::REG_CELL_HEIGHT:   cfg_next.cell_height   = cfg_data[7:0];
                bfgl_pkg::REG_GLYPH_PADDING: cfg_next.glyph_padding = cfg_data[7:0];
                bfgl_pkg::REG_ATLAS_WIDTH:   cfg_next.atlas_width   = cfg_data;
                bfgl_pkg::REG_ORIGIN_X:      cfg_next.origin_x      = cfg_data[7:0];
                bfgl_pkg::REG_ORIGIN_Y:      cfg_next.origin_y      = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_width    <= bfgl_pkg::CELL_WIDTH_RST;
            cfg_reg.cell_height   <= bfgl_pkg::CELL_HEIGHT_RST;
            cfg_reg.glyph_padding <= bfgl_pkg::GLYPH_PADDING_RST;
            cfg_reg.atlas_width   <= bfgl_pkg::ATLAS_WIDTH_RST;
            cfg_reg.origin_x      <= bfgl_pkg::ORIGIN_X_RST;
            cfg_reg.origin_y      <= bfgl_pkg::ORIGIN_Y_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // classify and track the pen
    bfgl_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .char_code        (s_tdata),
        .first_of_message (s_tuser),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_entry       (push_entry)
    );

    // decoupling queue
    bfgl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // atlas stepping and result register
    bfgl_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_entry       (pop_entry),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_kind        (out_kind),
        .out_glyph_index (out_glyph_index),
        .out_screen_x    (out_screen_x),
        .out_screen_y    (out_screen_y),
        .out_atlas_u     (out_atlas_u),
        .out_atlas_v     (out_atlas_v)
    );

    // result packing
    assign m_tuser = out_kind;
    assign m_tdata = {1'b0, out_atlas_v, out_atlas_u, out_screen_y, out_screen_x,
                      out_glyph_index};

    // results carry a defined kind
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == bfgl_pkg::KIND_GLYPH || m_tuser == bfgl_pkg::KIND_NEWLINE ||
                      m_tuser == bfgl_pkg::KIND_UNKNOWN))
        else $error("result with undefined kind");

    // newline and unknown results carry no placement
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != bfgl_pkg::KIND_GLYPH) |-> (m_tdata == '0))
        else $error("non-glyph result carries placement data");

    // glyph index stays inside the font
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_glyph_index < bfgl_pkg::GLYPH_COUNT))
        else $error("glyph index out of font range");

    // back end takes no new request in the cycle after it took one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |=> !pop_ready)
        else $error("back end took a request without stepping it");

endmodule

`default_nettype wire
